// File: rtl/pfr_pkg.sv
// Package for the Pareto front ranking block: sizes, word and entry types,
// controller commands and status, and the controller state encoding.
// No dependencies.
package pfr_pkg;

	localparam int MAX_POINTS     = 1024;
	localparam int MAX_OBJECTIVES = 8;
	localparam int KEY_SLOTS      = MAX_OBJECTIVES - 1;
	localparam int KEY_W          = 32;
	localparam int FIELD_W        = 10;
	localparam int FIELD_MAX      = (1 << FIELD_W) - 1;
	localparam int PTR_W          = $clog2(MAX_POINTS);
	localparam int CNT_W          = $clog2(MAX_POINTS + 1);
	localparam int CFG_W          = 4;
	localparam logic [CFG_W-1:0] NUM_OBJ_RESET = CFG_W'(2);

	typedef struct packed {
		logic              start_set;
		logic signed [31:0] obj_1;
		logic signed [31:0] obj_2;
		logic signed [31:0] obj_3;
		logic signed [31:0] obj_4;
		logic signed [31:0] obj_5;
		logic signed [31:0] obj_6;
		logic signed [31:0] obj_7;
	} pfr_in_t;

	typedef struct packed {
		logic [FIELD_W-1:0] front_rank;
		logic [FIELD_W-1:0] point_index;
		logic               overflow;
	} pfr_out_t;

	// One stored point: its rank and all of its remaining objective keys.
	typedef struct packed {
		logic [FIELD_W-1:0]                rank;
		logic [KEY_SLOTS-1:0][KEY_W-1:0]   keys;
	} pfr_entry_t;

	localparam int ENTRY_W = $bits(pfr_entry_t);

	typedef struct packed {
		logic load;
		logic scan;
		logic commit;
	} pfr_cmd_t;

	typedef struct packed {
		logic empty;
		logic last;
		logic busy;
		logic out_free;
	} pfr_stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_COMMIT
	} pfr_state_t;

	// Saturate a point count to the width of a result field.
	function automatic logic [FIELD_W-1:0] sat_field(input logic [CNT_W-1:0] v);
		logic [31:0] wide;
		wide = 32'(v);
		if (wide > 32'(FIELD_MAX)) begin
			return FIELD_W'(FIELD_MAX);
		end
		return FIELD_W'(wide);
	endfunction

endpackage

// File: rtl/pfr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module pfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/pfr_datapath.sv
// Datapath of the Pareto front ranking block: current word, point store,
// dominance compare pipeline, rank accumulator and output register.
// Depends on pfr_pkg and pfr_ram.
module pfr_datapath
	import pfr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  pfr_in_t          in_data,
	input  logic             cfg_valid,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             out_stall,
	output logic             out_valid,
	output pfr_out_t         out_data,
	input  pfr_cmd_t         cmd,
	output pfr_stat_t        stat
);

	pfr_in_t                       cur_q;
	logic [CFG_W-1:0]              num_obj_q;
	logic [CNT_W-1:0]              count_q;
	logic [CNT_W-1:0]              scan_q;
	logic                          v_s1;
	logic                          v_s2;
	logic                          dom_s2;
	logic [FIELD_W-1:0]            cand_s2;
	logic [FIELD_W-1:0]            rank_q;
	logic                          out_valid_q;
	pfr_out_t                      out_q;
	logic [KEY_SLOTS-1:0][KEY_W-1:0] cur_keys;
	logic [KEY_SLOTS-1:0]          act_mask;
	logic [CFG_W-1:0]              num_obj_c;
	pfr_entry_t                    rd_entry;
	pfr_entry_t                    wr_entry;
	logic [ENTRY_W-1:0]            rd_raw;
	logic                          dom;
	logic                          full;
	logic [CNT_W-1:0]              scan_next;

	assign cur_keys = {cur_q.obj_7, cur_q.obj_6, cur_q.obj_5, cur_q.obj_4,
		cur_q.obj_3, cur_q.obj_2, cur_q.obj_1};

	// A register value of zero acts as one, anything above the maximum as the maximum.
	always_comb begin
		num_obj_c = num_obj_q;
		if (num_obj_q == '0) begin
			num_obj_c = CFG_W'(1);
		end else if (num_obj_q > CFG_W'(MAX_OBJECTIVES)) begin
			num_obj_c = CFG_W'(MAX_OBJECTIVES);
		end
		for (int k = 0; k < KEY_SLOTS; k++) begin
			act_mask[k] = (CFG_W'(k + 1) < num_obj_c);
		end
	end

	assign full      = (count_q == CNT_W'(MAX_POINTS));
	assign scan_next = scan_q + CNT_W'(1);

	assign wr_entry.rank = rank_q;
	assign wr_entry.keys = cur_keys;

	pfr_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_POINTS)
	) u_store (
		.clk  (clk),
		.we   (cmd.commit && !full),
		.waddr(count_q[PTR_W-1:0]),
		.wdata(wr_entry),
		.re   (cmd.scan),
		.raddr(scan_q[PTR_W-1:0]),
		.rdata(rd_raw)
	);

	assign rd_entry = pfr_entry_t'(rd_raw);

	// The stored point dominates unless some active key of it is larger.
	always_comb begin
		dom = 1'b1;
		for (int k = 0; k < KEY_SLOTS; k++) begin
			if (act_mask[k] && ($signed(rd_entry.keys[k]) > $signed(cur_keys[k]))) begin
				dom = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_obj_q   <= NUM_OBJ_RESET;
			count_q     <= '0;
			scan_q      <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				num_obj_q <= cfg_data;
			end
			v_s1 <= cmd.scan;
			v_s2 <= v_s1;
			if (cmd.load) begin
				scan_q <= '0;
				if (in_data.start_set) begin
					count_q <= '0;
				end
			end else if (cmd.scan) begin
				scan_q <= scan_next;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
				if (!full) begin
					count_q <= count_q + CNT_W'(1);
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_q <= in_data;
		end
		dom_s2  <= dom;
		cand_s2 <= (rd_entry.rank == FIELD_W'(FIELD_MAX)) ? rd_entry.rank
			: rd_entry.rank + FIELD_W'(1);
		if (cmd.load) begin
			rank_q <= '0;
		end else if (v_s2 && dom_s2 && (cand_s2 > rank_q)) begin
			rank_q <= cand_s2;
		end
		if (cmd.commit) begin
			out_q.front_rank  <= rank_q;
			out_q.point_index <= full ? '0 : sat_field(count_q);
			out_q.overflow    <= full;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign stat.empty    = (count_q == '0);
	assign stat.last     = (scan_next == count_q);
	assign stat.busy     = v_s1 || v_s2;
	assign stat.out_free = !out_valid_q || !out_stall;

endmodule

// File: rtl/pfr_ctrl.sv
// Controller of the Pareto front ranking block: sequences accept, scan of the
// stored points, pipeline drain and commit of the result word.
// Depends on pfr_pkg.
module pfr_ctrl
	import pfr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output pfr_cmd_t  cmd,
	input  pfr_stat_t stat
);

	pfr_state_t state_q;
	pfr_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (stat.empty) begin
					state_d = ST_DRAIN;
				end else begin
					cmd.scan = 1'b1;
					if (stat.last) begin
						state_d = ST_DRAIN;
					end
				end
			end
			ST_DRAIN: begin
				if (!stat.busy) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/pareto_front_rank.sv
// Top level of the Pareto front ranking block.
// Depends on pfr_pkg, pfr_ctrl and pfr_datapath.
//
// Points arrive one word at a time, ordered by the first objective; each word
// yields one result word holding the point's front rank, its index in the set
// and an overflow flag. After acceptance, the block reads each of the N
// points already stored in the current set (at most 1024) through the single
// read port of the point store, one read per point; the read, compare and
// rank accumulator registers then drain and the result word is committed.
// An empty set skips the reads and goes through the empty check, the drain
// and the commit. The next word is taken only once the block is back in
// idle after the commit. A result waiting in the output register does not
// hold off the next item; only its commit waits for the register to free.
// The store needs no clearing after reset, and the objective count register
// may be written at any time the block is idle.
module pareto_front_rank
	import pfr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  pfr_in_t          in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output pfr_out_t         out_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data
);

	pfr_cmd_t  cmd;
	pfr_stat_t stat;

	assign cfg_ready = 1'b1;

	pfr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd     (cmd),
		.stat    (stat)
	);

	pfr_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cfg_valid(cfg_valid),
		.cfg_data (cfg_data),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.out_data (out_data),
		.cmd      (cmd),
		.stat     (stat)
	);

endmodule

// File: rtl/pfr_check.sv
// Port-level checker for the Pareto front ranking block, bound to the top.
// Depends on pfr_pkg.
module pfr_check
	import pfr_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     in_valid,
	input logic     in_stall,
	input logic     out_valid,
	input logic     out_stall,
	input pfr_out_t out_data
);

	// A waiting result word holds until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	// Every accepted word is worked on alone: the input stalls right after.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after an accept");

	// A point that was not stored reports index zero.
	a_overflow_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.overflow |-> out_data.point_index == '0)
		else $error("overflow result with non-zero index");

	// A stored point cannot rank deeper than the number of points before it.
	a_rank_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.overflow |-> out_data.front_rank <= out_data.point_index)
		else $error("front rank exceeds point index");

endmodule

bind pareto_front_rank pfr_check u_pfr_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_data (out_data)
);
